FILE: hdl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants for the sorter mode/debounce control
// Item and result records, key codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sdc_pkg;

    localparam int FUNC_W  = 3;
    localparam int NOW_W   = 32;
    localparam int CFG_W   = 16;
    localparam int TOTAL_W = 16;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_NONE   = 3'd0,
        FUNC_PASS   = 3'd1,
        FUNC_REJECT = 3'd2,
        FUNC_TOGGLE = 3'd3,
        FUNC_RESET  = 3'd4
    } sdc_func_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [CFG_W-1:0] LOCKOUT_RESET  = 16'd2000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NOW_W-1:0]  now_ms;
        logic              ball_present;
        logic              ball_is_blue;
        logic              mode_btn;
        logic              pass_btn;
        logic              fail_btn;
    } sdc_item_t;

    typedef struct packed {
        logic               mode_on;
        logic               pass_kick;
        logic               fail_kick;
        logic               pass_lamp;
        logic               fail_lamp;
        logic [TOTAL_W-1:0] pass_total;
        logic [TOTAL_W-1:0] fail_total;
    } sdc_result_t;

    typedef struct packed {
        logic auto_mode;
        logic sort_ready;
        logic lock_pending;
    } sdc_status_t;

endpackage

`default_nettype wire

FILE: hdl/sdc_debounce.sv
// ----------------------------------------------------------------------------
// sdc_debounce: one switch debouncer
// Records the last time the switch was seen high and fires once after the
// quiet time has run out. Holds its state when the sample enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_debounce #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         sample_en,
    input  wire logic                         level,
    input  wire logic [TIME_BITS-1:0]         now,
    input  wire logic [sdc_pkg::CFG_W-1:0]    debounce_ms,
    output logic                              fire
);
    import sdc_pkg::*;

    logic                 pending_reg, pending_next;
    logic [TIME_BITS-1:0] seen_reg, seen_next;
    logic                 pend_eff;
    logic [TIME_BITS-1:0] seen_eff;
    logic [TIME_BITS-1:0] diff;

    always_comb begin
        pend_eff = level | pending_reg;
        seen_eff = level ? now : seen_reg;
        // wrap-safe: expired once seen + debounce - now goes negative
        diff     = seen_eff + TIME_BITS'(debounce_ms) - now;
        fire     = sample_en & pend_eff & diff[TIME_BITS-1];
        pending_next = pending_reg;
        seen_next    = seen_reg;
        if (sample_en) begin
            pending_next = pend_eff & ~diff[TIME_BITS-1];
            seen_next    = seen_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        seen_reg <= seen_next;
    end

endmodule

`default_nettype wire

FILE: hdl/sdc_core.sv
// ----------------------------------------------------------------------------
// sdc_core: control step logic
// Mode, lockout, switch debouncers, saturating totals and lamps. One step
// is taken in every cycle with step_en high.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_core #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step_en,
    input  sdc_pkg::sdc_item_t             item,
    input  wire logic [sdc_pkg::CFG_W-1:0] debounce_ms,
    input  wire logic [sdc_pkg::CFG_W-1:0] lockout_ms,
    output sdc_pkg::sdc_result_t           result,
    output sdc_pkg::sdc_status_t           status
);
    import sdc_pkg::*;

    logic                  auto_reg, auto_next;
    logic                  ready_reg, ready_next;
    logic                  lock_pend_reg, lock_pend_next;
    logic [TIME_BITS-1:0]  lock_start_reg, lock_start_next;
    logic [COUNT_BITS-1:0] pass_cnt_reg, pass_cnt_next;
    logic [COUNT_BITS-1:0] fail_cnt_reg, fail_cnt_next;
    logic                  pass_lamp_reg, pass_lamp_next;
    logic                  fail_lamp_reg, fail_lamp_next;

    logic [TIME_BITS-1:0]  now;
    logic                  flip, pass_fire, fail_fire;
    logic                  arm, do_pass, do_fail, lock_pend_eff, lock_done;
    logic [TIME_BITS-1:0]  lock_start_eff, lock_diff;

    assign now = TIME_BITS'(item.now_ms);

    sdc_debounce #(.TIME_BITS(TIME_BITS)) u_mode_db (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_en   (step_en),
        .level       (item.mode_btn),
        .now         (now),
        .debounce_ms (debounce_ms),
        .fire        (flip)
    );

    // pass/fail buttons are ignored, and keep their state, in auto mode
    sdc_debounce #(.TIME_BITS(TIME_BITS)) u_pass_db (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_en   (step_en & ~auto_reg),
        .level       (item.pass_btn),
        .now         (now),
        .debounce_ms (debounce_ms),
        .fire        (pass_fire)
    );

    sdc_debounce #(.TIME_BITS(TIME_BITS)) u_fail_db (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_en   (step_en & ~auto_reg),
        .level       (item.fail_btn),
        .now         (now),
        .debounce_ms (debounce_ms),
        .fire        (fail_fire)
    );

    always_comb begin
        arm = auto_reg & item.ball_present & ready_reg;
        if (auto_reg) begin
            do_pass = arm & item.ball_is_blue;
            do_fail = arm & ~item.ball_is_blue;
        end else begin
            do_pass = (item.func == FUNC_PASS) | pass_fire;
            do_fail = (item.func == FUNC_REJECT) | fail_fire;
        end

        lock_pend_eff  = arm | lock_pend_reg;
        lock_start_eff = arm ? now : lock_start_reg;
        lock_diff      = lock_start_eff + TIME_BITS'(lockout_ms) - now;
        lock_done      = lock_pend_eff & lock_diff[TIME_BITS-1];

        lock_pend_next  = lock_pend_eff & ~lock_done;
        lock_start_next = lock_start_eff;
        ready_next      = lock_done | (ready_reg & ~arm);

        auto_next = auto_reg;
        if ((item.func == FUNC_TOGGLE) || flip) begin
            auto_next = ~auto_reg;
        end

        pass_cnt_next = pass_cnt_reg;
        fail_cnt_next = fail_cnt_reg;
        if (do_pass && (pass_cnt_reg != '1)) begin
            pass_cnt_next = pass_cnt_reg + 1'b1;
        end
        if (do_fail && (fail_cnt_reg != '1)) begin
            fail_cnt_next = fail_cnt_reg + 1'b1;
        end

        // a fail sort in the same step wins the lamps
        pass_lamp_next = pass_lamp_reg;
        fail_lamp_next = fail_lamp_reg;
        if (do_fail) begin
            pass_lamp_next = 1'b0;
            fail_lamp_next = 1'b1;
        end else if (do_pass) begin
            pass_lamp_next = 1'b1;
            fail_lamp_next = 1'b0;
        end

        // reset key: kicks of this step still count, then clear
        if (item.func == FUNC_RESET) begin
            auto_next     = 1'b0;
            pass_cnt_next = '0;
            fail_cnt_next = '0;
        end

        result.mode_on    = auto_next;
        result.pass_kick  = do_pass;
        result.fail_kick  = do_fail;
        result.pass_lamp  = pass_lamp_next;
        result.fail_lamp  = fail_lamp_next;
        result.pass_total = TOTAL_W'(pass_cnt_next);
        result.fail_total = TOTAL_W'(fail_cnt_next);

        status.auto_mode    = auto_reg;
        status.sort_ready   = ready_reg;
        status.lock_pending = lock_pend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_reg      <= 1'b0;
            ready_reg     <= 1'b1;
            lock_pend_reg <= 1'b0;
            pass_cnt_reg  <= '0;
            fail_cnt_reg  <= '0;
            pass_lamp_reg <= 1'b0;
            fail_lamp_reg <= 1'b0;
        end else if (step_en) begin
            auto_reg      <= auto_next;
            ready_reg     <= ready_next;
            lock_pend_reg <= lock_pend_next;
            pass_cnt_reg  <= pass_cnt_next;
            fail_cnt_reg  <= fail_cnt_next;
            pass_lamp_reg <= pass_lamp_next;
            fail_lamp_reg <= fail_lamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            lock_start_reg <= lock_start_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sorter_mode_and_debounce_control_top.sv
// ----------------------------------------------------------------------------
// sorter_mode_and_debounce_control_top: ball sorter mode and debounce control
// Input request register, control step logic and result register.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  s_*      in         s_valid / s_ready   func, now_ms, ball and switch flags
//  m_*      out        m_valid / m_ready   mode, kicks, lamps, totals
//  cfg_*    in         cfg_we              cfg_idx, cfg_wdata (no read-back)
//
//  One request per cycle while the result side is not stalled; an accepted
//  request passes the input register, then the step logic into the result reg.
//  The step state updates as a request moves into the result register.
//  A stalled result holds; the input register still takes one more request.
//  Reset clears mode, lockout, totals, lamps and loads the default timings.
//
`default_nettype none

module sorter_mode_and_debounce_control_top #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_we,
    input  wire logic [sdc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [sdc_pkg::CFG_W-1:0]     cfg_wdata,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sdc_pkg::FUNC_W-1:0]    s_func,
    input  wire logic [sdc_pkg::NOW_W-1:0]     s_now_ms,
    input  wire logic                          s_ball_present,
    input  wire logic                          s_ball_is_blue,
    input  wire logic                          s_mode_switch,
    input  wire logic                          s_pass_switch,
    input  wire logic                          s_fail_switch,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_mode_on,
    output logic                               m_pass_kick,
    output logic                               m_fail_kick,
    output logic                               m_pass_lamp,
    output logic                               m_fail_lamp,
    output logic [sdc_pkg::TOTAL_W-1:0]        m_pass_total,
    output logic [sdc_pkg::TOTAL_W-1:0]        m_fail_total
);
    import sdc_pkg::*;

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] lockout_reg;

    logic        in_valid_reg, in_valid_next;
    sdc_item_t   item_reg;
    logic        out_valid_reg, out_valid_next;
    sdc_result_t res_reg;
    sdc_result_t step_res;
    sdc_status_t status;
    logic        advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            lockout_reg  <= LOCKOUT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                CFG_LOCKOUT:  lockout_reg  <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // move the held request into the result register when it is free
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.func         <= s_func;
            item_reg.now_ms       <= s_now_ms;
            item_reg.ball_present <= s_ball_present;
            item_reg.ball_is_blue <= s_ball_is_blue;
            item_reg.mode_btn     <= s_mode_switch;
            item_reg.pass_btn     <= s_pass_switch;
            item_reg.fail_btn     <= s_fail_switch;
        end
        if (advance) begin
            res_reg <= step_res;
        end
    end

    sdc_core #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .item        (item_reg),
        .debounce_ms (debounce_reg),
        .lockout_ms  (lockout_reg),
        .result      (step_res),
        .status      (status)
    );

    assign m_valid      = out_valid_reg;
    assign m_mode_on    = res_reg.mode_on;
    assign m_pass_kick  = res_reg.pass_kick;
    assign m_fail_kick  = res_reg.fail_kick;
    assign m_pass_lamp  = res_reg.pass_lamp;
    assign m_fail_lamp  = res_reg.fail_lamp;
    assign m_pass_total = res_reg.pass_total;
    assign m_fail_total = res_reg.fail_total;

    a_step_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("step taken but no result posted");

    a_held_request_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held request lost while result stalled");

    a_lockout_tracks_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.sort_ready |-> status.lock_pending)
        else $error("sorter blocked with no lockout running");

    a_one_lamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_pass_lamp && m_fail_lamp))
        else $error("both lamps lit");

endmodule

`default_nettype wire

FILE: verif/sdc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdc_checker: result predictor and comparator for the sorter control block
// Watches the configuration port, the request and result channels. For every
// accepted control step it computes the expected mode, kicks, lamps and
// totals, queues them, and compares each delivered result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sdc_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_we,
    input  wire logic [sdc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [sdc_pkg::CFG_W-1:0]     cfg_wdata,

    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [sdc_pkg::FUNC_W-1:0]    s_func,
    input  wire logic [sdc_pkg::NOW_W-1:0]     s_now_ms,
    input  wire logic                          s_ball_present,
    input  wire logic                          s_ball_is_blue,
    input  wire logic                          s_mode_switch,
    input  wire logic                          s_pass_switch,
    input  wire logic                          s_fail_switch,

    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic                          m_mode_on,
    input  wire logic                          m_pass_kick,
    input  wire logic                          m_fail_kick,
    input  wire logic                          m_pass_lamp,
    input  wire logic                          m_fail_lamp,
    input  wire logic [sdc_pkg::TOTAL_W-1:0]   m_pass_total,
    input  wire logic [sdc_pkg::TOTAL_W-1:0]   m_fail_total,

    output int                                 errors,
    output int                                 pending,
    output int                                 checked
);
    import sdc_pkg::*;

    // timing registers as the block should hold them
    logic [CFG_W-1:0]   debounce_len;
    logic [CFG_W-1:0]   lockout_len;

    // control state mirror
    logic               auto_mode_q;
    logic               sort_ready_q;
    logic               lock_armed_q;
    logic [NOW_W-1:0]   lock_start_q;
    logic [2:0]         switch_armed;
    logic [NOW_W-1:0]   switch_seen [3];
    logic [TOTAL_W-1:0] pass_tally;
    logic [TOTAL_W-1:0] fail_tally;
    logic               pass_lit;
    logic               fail_lit;

    sdc_result_t        sort_results_due [$];

    // Wrap-safe: the wait is over once start + len - now goes negative.
    function automatic logic has_elapsed(input logic [NOW_W-1:0] start,
                                         input logic [CFG_W-1:0] len,
                                         input logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] diff;
        diff = start + {{(NOW_W-CFG_W){1'b0}}, len} - now;
        return diff[NOW_W-1];
    endfunction

    task automatic sample_switch(input int k, input logic level,
                                 input logic [NOW_W-1:0] now, output logic fire);
        if (level) begin
            switch_seen[k]  = now;
            switch_armed[k] = 1'b1;
        end
        fire = switch_armed[k] && has_elapsed(switch_seen[k], debounce_len, now);
        if (fire) begin
            switch_armed[k] = 1'b0;
        end
    endtask

    task automatic step_sorter(input sdc_item_t it, output sdc_result_t res);
        logic pass_cmd;
        logic fail_cmd;
        logic arm_lock;
        logic flip;
        logic fire;
        pass_cmd = 1'b0;
        fail_cmd = 1'b0;
        arm_lock = 1'b0;
        if (auto_mode_q) begin
            if (it.ball_present && sort_ready_q) begin
                if (it.ball_is_blue) begin
                    pass_cmd = 1'b1;
                end else begin
                    fail_cmd = 1'b1;
                end
                sort_ready_q = 1'b0;
                arm_lock     = 1'b1;
            end
        end else begin
            pass_cmd = (it.func == FUNC_PASS);
            fail_cmd = (it.func == FUNC_REJECT);
        end

        sample_switch(0, it.mode_btn, it.now_ms, flip);
        // pass and fail buttons are left alone while in auto mode
        if (!auto_mode_q) begin
            sample_switch(1, it.pass_btn, it.now_ms, fire);
            pass_cmd = pass_cmd | fire;
            sample_switch(2, it.fail_btn, it.now_ms, fire);
            fail_cmd = fail_cmd | fire;
        end

        if (arm_lock) begin
            lock_start_q = it.now_ms;
            lock_armed_q = 1'b1;
        end
        if (lock_armed_q && has_elapsed(lock_start_q, lockout_len, it.now_ms)) begin
            sort_ready_q = 1'b1;
            lock_armed_q = 1'b0;
        end

        if (it.func == FUNC_TOGGLE || flip) begin
            auto_mode_q = !auto_mode_q;
        end

        // fail is applied last, so it owns the lamps when both sort
        if (pass_cmd) begin
            if (pass_tally != '1) pass_tally = pass_tally + 1'b1;
            pass_lit = 1'b1;
            fail_lit = 1'b0;
        end
        if (fail_cmd) begin
            if (fail_tally != '1) fail_tally = fail_tally + 1'b1;
            pass_lit = 1'b0;
            fail_lit = 1'b1;
        end

        if (it.func == FUNC_RESET) begin
            auto_mode_q = 1'b0;
            pass_tally  = '0;
            fail_tally  = '0;
        end

        res.mode_on    = auto_mode_q;
        res.pass_kick  = pass_cmd;
        res.fail_kick  = fail_cmd;
        res.pass_lamp  = pass_lit;
        res.fail_lamp  = fail_lit;
        res.pass_total = pass_tally;
        res.fail_total = fail_tally;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        sdc_item_t   it;
        sdc_result_t want;
        if (!aresetn) begin
            debounce_len  = DEBOUNCE_RESET;
            lockout_len   = LOCKOUT_RESET;
            auto_mode_q   = 1'b0;
            sort_ready_q  = 1'b1;
            lock_armed_q  = 1'b0;
            lock_start_q  = '0;
            switch_armed  = '0;
            for (int k = 0; k < 3; k++) switch_seen[k] = '0;
            pass_tally    = '0;
            fail_tally    = '0;
            pass_lit      = 1'b0;
            fail_lit      = 1'b0;
            sort_results_due.delete();
            errors        = 0;
            checked       = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_DEBOUNCE: begin
                        debounce_len = cfg_wdata;
                    end
                    CFG_LOCKOUT: begin
                        lockout_len = cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end

            if (m_valid && m_ready) begin
                if (sort_results_due.size() == 0) begin
                    $error("result delivered with no request outstanding");
                    errors++;
                end else begin
                    want = sort_results_due.pop_front();
                    check_field("mode_on",    32'(want.mode_on),    32'(m_mode_on));
                    check_field("pass_kick",  32'(want.pass_kick),  32'(m_pass_kick));
                    check_field("fail_kick",  32'(want.fail_kick),  32'(m_fail_kick));
                    check_field("pass_lamp",  32'(want.pass_lamp),  32'(m_pass_lamp));
                    check_field("fail_lamp",  32'(want.fail_lamp),  32'(m_fail_lamp));
                    check_field("pass_total", 32'(want.pass_total), 32'(m_pass_total));
                    check_field("fail_total", 32'(want.fail_total), 32'(m_fail_total));
                    checked++;
                end
            end

            if (s_valid && s_ready) begin
                it.func         = s_func;
                it.now_ms       = s_now_ms;
                it.ball_present = s_ball_present;
                it.ball_is_blue = s_ball_is_blue;
                it.mode_btn     = s_mode_switch;
                it.pass_btn     = s_pass_switch;
                it.fail_btn     = s_fail_switch;
                step_sorter(it, want);
                sort_results_due.push_back(want);
            end
        end
        pending <= sort_results_due.size();
    end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorter mode and debounce control
// Directed control steps for the sort, debounce, lockout and key cases, then
// random step sequences under several timing settings, then a short run of
// back-to-back steps with no idling. Checking lives in sdc_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import sdc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_STEPS = 220;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx      = '0;
    logic [CFG_W-1:0]   cfg_wdata      = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [FUNC_W-1:0]  s_func         = '0;
    logic [NOW_W-1:0]   s_now_ms       = '0;
    logic               s_ball_present = 1'b0;
    logic               s_ball_is_blue = 1'b0;
    logic               s_mode_switch  = 1'b0;
    logic               s_pass_switch  = 1'b0;
    logic               s_fail_switch  = 1'b0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic               m_mode_on;
    logic               m_pass_kick;
    logic               m_fail_kick;
    logic               m_pass_lamp;
    logic               m_fail_lamp;
    logic [TOTAL_W-1:0] m_pass_total;
    logic [TOTAL_W-1:0] m_fail_total;

    int                 errors;
    int                 pending;
    int                 checked;

    logic               idle_on        = 1'b1;
    logic               want_long_hold = 1'b0;
    logic               long_hold_done = 1'b0;
    int                 stall_left     = 0;
    int                 quiet_cycles   = 0;
    int                 time_span      = 2;
    int                 settings_run   = 1;
    logic [NOW_W-1:0]   clock_ms       = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorter_mode_and_debounce_control_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_now_ms       (s_now_ms),
        .s_ball_present (s_ball_present),
        .s_ball_is_blue (s_ball_is_blue),
        .s_mode_switch  (s_mode_switch),
        .s_pass_switch  (s_pass_switch),
        .s_fail_switch  (s_fail_switch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode_on      (m_mode_on),
        .m_pass_kick    (m_pass_kick),
        .m_fail_kick    (m_fail_kick),
        .m_pass_lamp    (m_pass_lamp),
        .m_fail_lamp    (m_fail_lamp),
        .m_pass_total   (m_pass_total),
        .m_fail_total   (m_fail_total)
    );

    sdc_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_now_ms       (s_now_ms),
        .s_ball_present (s_ball_present),
        .s_ball_is_blue (s_ball_is_blue),
        .s_mode_switch  (s_mode_switch),
        .s_pass_switch  (s_pass_switch),
        .s_fail_switch  (s_fail_switch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mode_on      (m_mode_on),
        .m_pass_kick    (m_pass_kick),
        .m_fail_kick    (m_fail_kick),
        .m_pass_lamp    (m_pass_lamp),
        .m_fail_lamp    (m_fail_lamp),
        .m_pass_total   (m_pass_total),
        .m_fail_total   (m_fail_total),
        .errors         (errors),
        .pending        (pending),
        .checked        (checked)
    );

    // result side: random stall bursts plus one long hold to back up the block
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (want_long_hold && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic sdc_item_t make_step(input logic [FUNC_W-1:0] f,
                                            input logic [NOW_W-1:0] t,
                                            input logic present, input logic blue,
                                            input logic ms, input logic ps,
                                            input logic fs);
        sdc_item_t it;
        it.func         = f;
        it.now_ms       = t;
        it.ball_present = present;
        it.ball_is_blue = blue;
        it.mode_btn     = ms;
        it.pass_btn     = ps;
        it.fail_btn     = fs;
        return it;
    endfunction

    // Mostly a steadily advancing clock; a few steps jump to a random time.
    function automatic sdc_item_t rand_step();
        sdc_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            it.now_ms = $urandom();
            if (pick < 2) clock_ms = it.now_ms;
        end else begin
            clock_ms  = clock_ms + $urandom_range(0, time_span);
            it.now_ms = clock_ms;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.func = FUNC_NONE;
        end else if (pick < 67) begin
            it.func = FUNC_PASS;
        end else if (pick < 79) begin
            it.func = FUNC_REJECT;
        end else if (pick < 88) begin
            it.func = FUNC_TOGGLE;
        end else if (pick < 91) begin
            it.func = FUNC_RESET;
        end else begin
            it.func = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        end
        it.ball_present = 1'($urandom_range(0, 1));
        it.ball_is_blue = 1'($urandom_range(0, 1));
        it.mode_btn     = ($urandom_range(0, 14) == 0);
        it.pass_btn     = ($urandom_range(0, 5) == 0);
        it.fail_btn     = ($urandom_range(0, 5) == 0);
        return it;
    endfunction

    // Offer one request, after a random idle gap when idling is on, and hold it until taken.
    task automatic send_step(input sdc_item_t it);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= it.func;
        s_now_ms       <= it.now_ms;
        s_ball_present <= it.ball_present;
        s_ball_is_blue <= it.ball_is_blue;
        s_mode_switch  <= it.mode_btn;
        s_pass_switch  <= it.pass_btn;
        s_fail_switch  <= it.fail_btn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lock);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge aclk);
        cfg_idx   <= CFG_LOCKOUT;
        cfg_wdata <= lock;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        time_span = int'(((deb > lock) ? deb : lock) / 4) + 2;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lock);
        wait_drained();
        set_timing(deb, lock);
        settings_run++;
        // start the long output hold (first phase only) while requests keep coming
        want_long_hold <= 1'b1;
        repeat (PHASE_STEPS) send_step(rand_step());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default timings: debounce 100, lockout 2000
        send_step(make_step(FUNC_NONE,      32'd0,    0, 0, 0, 0, 0));
        send_step(make_step(FUNC_PASS,      32'd10,   1, 1, 0, 0, 0));
        send_step(make_step(FUNC_REJECT,    32'd20,   1, 0, 0, 0, 0));
        send_step(make_step(FUNC_UNUSED_LO, 32'd30,   0, 0, 0, 0, 0));
        send_step(make_step(FUNC_UNUSED_LO + 1'b1, 32'd31, 1, 0, 0, 0, 0));
        send_step(make_step(FUNC_UNUSED_HI, 32'd32,   1, 1, 0, 0, 0));
        // pass button fires together with the reject key: both sorts
        send_step(make_step(FUNC_NONE,      32'd40,   0, 0, 0, 1, 0));
        send_step(make_step(FUNC_REJECT,    32'd200,  0, 0, 0, 0, 0));
        // fail button: exactly the debounce time is not enough, one more is
        send_step(make_step(FUNC_NONE,      32'd210,  0, 0, 0, 0, 1));
        send_step(make_step(FUNC_NONE,      32'd310,  0, 0, 0, 0, 0));
        send_step(make_step(FUNC_NONE,      32'd311,  0, 0, 0, 0, 0));
        // auto mode: sort, lockout boundary, then the next ball
        send_step(make_step(FUNC_TOGGLE,    32'd320,  0, 0, 0, 0, 0));
        send_step(make_step(FUNC_NONE,      32'd330,  1, 1, 0, 1, 0));
        send_step(make_step(FUNC_NONE,      32'd2330, 1, 0, 0, 0, 0));
        send_step(make_step(FUNC_NONE,      32'd2331, 1, 0, 0, 0, 0));
        send_step(make_step(FUNC_NONE,      32'd2332, 1, 0, 0, 0, 0));
        // mode button back to manual; the pass key in that step is ignored
        send_step(make_step(FUNC_NONE,      32'd2340, 0, 0, 1, 0, 0));
        send_step(make_step(FUNC_PASS,      32'd2500, 0, 0, 0, 0, 0));
        send_step(make_step(FUNC_PASS,      32'd2510, 0, 0, 0, 0, 0));
        // reset key: the button sort still counts, then totals clear
        send_step(make_step(FUNC_NONE,      32'd2520, 0, 0, 0, 1, 0));
        send_step(make_step(FUNC_RESET,     32'd2700, 1, 1, 0, 0, 0));
        // debounce across the time wrap
        send_step(make_step(FUNC_PASS,      32'hFFFF_FFF0, 0, 0, 0, 0, 1));
        send_step(make_step(FUNC_NONE,      32'h0000_0100, 0, 0, 0, 0, 0));
        send_step(make_step(FUNC_UNUSED_HI, 32'hFFFF_FFFF, 1, 1, 1, 1, 1));
        // toggle key and mode button in one step flip only once
        send_step(make_step(FUNC_TOGGLE,    32'h8000_0000, 1, 0, 0, 0, 0));

        run_phase(DEBOUNCE_RESET, LOCKOUT_RESET);
        run_phase(16'd1, 16'd1);
        run_phase(16'hFFFF, 16'hFFFF);
        run_phase(16'd0, 16'd0);
        run_phase(16'd1, 16'hFFFF);
        run_phase(16'hFFFF, 16'd1);
        run_phase(CFG_W'($urandom_range(2, 500)), CFG_W'($urandom_range(2, 5000)));
        run_phase(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(1, 65535)));

        // no idling from here on: back-to-back steps at default timings
        wait_drained();
        idle_on <= 1'b0;
        set_timing(DEBOUNCE_RESET, LOCKOUT_RESET);
        send_step(make_step(FUNC_RESET, clock_ms, 0, 0, 0, 0, 0));
        repeat (60) send_step(rand_step());

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("summary: %0d control steps checked under %0d timing settings,",
                 checked, settings_run);
        $display("summary: including a long output stall and a back-to-back tail");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
